// ----- rtl/tri_pkg.sv -----
// Shared types, constants and the back-end microprogram for the trilateration core.
// Depends on nothing; every other file but tri_if uses it.
package tri_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int REG_DEPTH   = 64;
    localparam int RADDR_W     = 6;
    localparam int PROG_DEPTH  = 256;
    localparam int PC_W        = 8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOMEET = 2'd1;
    localparam logic [1:0] ST_DEGEN  = 2'd2;

    // Scratch register file map.
    localparam int RG_C1 = 0;
    localparam int RG_A  = 3;
    localparam int RG_B  = 6;
    localparam int RG_R1 = 9;
    localparam int RG_R2 = 10;
    localparam int RG_R3 = 11;
    localparam int RG_T0 = 12;
    localparam int RG_T1 = 13;
    localparam int RG_TT = 14;
    localparam int RG_D2 = 17;
    localparam int RG_DL = 18;
    localparam int RG_EX = 19;
    localparam int RG_IV = 22;
    localparam int RG_NL = 23;
    localparam int RG_EY = 24;
    localparam int RG_EZ = 27;
    localparam int RG_JV = 30;
    localparam int RG_XV = 31;
    localparam int RG_YV = 32;
    localparam int RG_ZV = 33;

    typedef enum logic [3:0] {
        OP_END, OP_LD, OP_ADD, OP_SUB, OP_OR, OP_SHL, OP_SHRR, OP_MUL,
        OP_DIVR, OP_SQRT, OP_CHKZ, OP_CHKLE, OP_CHKBIG, OP_CHKNEG, OP_SAT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [RADDR_W-1:0] dst;
        logic [RADDR_W-1:0] sa;
        logic [RADDR_W-1:0] sb;
        logic [6:0]         amt;
    } instr_t;

    // One sphere triple after the front end: C1, A = C2 - C1, B = C3 - C1, squared radii.
    typedef struct packed {
        logic [2:0][31:0] c1;
        logic [2:0][32:0] av;
        logic [2:0][32:0] bv;
        logic [2:0][47:0] rsq;
    } item_t;

    function automatic instr_t mk(op_t op, int dst, int sa, int sb, int amt);
        instr_t r;
        r.op  = op;
        r.dst = RADDR_W'(dst);
        r.sa  = RADDR_W'(sa);
        r.sb  = RADDR_W'(sb);
        r.amt = 7'(amt);
        return r;
    endfunction

    // The whole fix as a straight-line program with early exits.
    function automatic instr_t tri_prog(logic [PC_W-1:0] pc, int frac);
        instr_t p [PROG_DEPTH];
        int n;
        int k;
        int pp;
        int qq;
        for (k = 0; k < PROG_DEPTH; k++) p[k] = mk(OP_END, 0, 0, 0, 0);
        n = 0;
        for (k = 0; k < 12; k++) begin p[n] = mk(OP_LD, k, k, 0, 0); n++; end
        // a cross b, into the TT slots
        for (k = 0; k < 3; k++) begin
            pp = (k == 2) ? 0 : k + 1;
            qq = (k == 0) ? 2 : k - 1;
            p[n] = mk(OP_MUL, RG_T0, RG_A + pp, RG_B + qq, 0); n++;
            p[n] = mk(OP_MUL, RG_T1, RG_A + qq, RG_B + pp, 0); n++;
            p[n] = mk(OP_SUB, RG_TT + k, RG_T0, RG_T1, 0); n++;
        end
        p[n] = mk(OP_OR, RG_T0, RG_TT, RG_TT + 1, 0); n++;
        p[n] = mk(OP_OR, RG_T0, RG_T0, RG_TT + 2, 0); n++;
        p[n] = mk(OP_CHKZ, 0, RG_T0, 0, 0); n++;
        // d^2 and d
        p[n] = mk(OP_MUL, RG_T0, RG_A, RG_A, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_A + 1, RG_A + 1, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_A + 2, RG_A + 2, 0); n++;
        p[n] = mk(OP_ADD, RG_D2, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_SHL, RG_T0, RG_D2, 0, 32); n++;
        p[n] = mk(OP_SQRT, RG_DL, RG_T0, 0, 0); n++;
        for (k = 0; k < 3; k++) begin
            p[n] = mk(OP_SHL, RG_T0, RG_A + k, 0, 46); n++;
            p[n] = mk(OP_DIVR, RG_EX + k, RG_T0, RG_DL, 0); n++;
        end
        // i
        p[n] = mk(OP_MUL, RG_T0, RG_EX, RG_B, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_EX + 1, RG_B + 1, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_EX + 2, RG_B + 2, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_SHRR, RG_IV, RG_T0, 0, 14); n++;
        // t = b*2^16 - i*ex
        for (k = 0; k < 3; k++) begin
            p[n] = mk(OP_SHL, RG_T0, RG_B + k, 0, 16); n++;
            p[n] = mk(OP_MUL, RG_T1, RG_IV, RG_EX + k, 0); n++;
            p[n] = mk(OP_SHRR, RG_T1, RG_T1, 0, 30); n++;
            p[n] = mk(OP_SUB, RG_TT + k, RG_T0, RG_T1, 0); n++;
        end
        p[n] = mk(OP_MUL, RG_T0, RG_TT, RG_TT, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_TT + 1, RG_TT + 1, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_TT + 2, RG_TT + 2, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_SQRT, RG_NL, RG_T0, 0, 0); n++;
        p[n] = mk(OP_CHKZ, 0, RG_NL, 0, 0); n++;
        for (k = 0; k < 3; k++) begin
            p[n] = mk(OP_SHL, RG_T0, RG_TT + k, 0, 30); n++;
            p[n] = mk(OP_DIVR, RG_EY + k, RG_T0, RG_NL, 0); n++;
        end
        for (k = 0; k < 3; k++) begin
            pp = (k == 2) ? 0 : k + 1;
            qq = (k == 0) ? 2 : k - 1;
            p[n] = mk(OP_MUL, RG_T0, RG_EX + pp, RG_EY + qq, 0); n++;
            p[n] = mk(OP_MUL, RG_T1, RG_EX + qq, RG_EY + pp, 0); n++;
            p[n] = mk(OP_SUB, RG_T0, RG_T0, RG_T1, 0); n++;
            p[n] = mk(OP_SHRR, RG_EZ + k, RG_T0, 0, 30); n++;
        end
        // j
        p[n] = mk(OP_MUL, RG_T0, RG_EY, RG_B, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_EY + 1, RG_B + 1, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_EY + 2, RG_B + 2, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_SHRR, RG_JV, RG_T0, 0, 14); n++;
        p[n] = mk(OP_CHKLE, 0, RG_JV, 0, 0); n++;
        // x
        p[n] = mk(OP_SUB, RG_T0, RG_R1, RG_R2, 0); n++;
        p[n] = mk(OP_SHL, RG_T0, RG_T0, 0, frac); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_D2, 0); n++;
        p[n] = mk(OP_SHL, RG_T0, RG_T0, 0, 31); n++;
        p[n] = mk(OP_DIVR, RG_XV, RG_T0, RG_DL, 0); n++;
        p[n] = mk(OP_CHKBIG, 0, RG_XV, 0, 0); n++;
        // y
        p[n] = mk(OP_SUB, RG_T0, RG_R1, RG_R3, 0); n++;
        p[n] = mk(OP_SHL, RG_T0, RG_T0, 0, frac + 32); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_IV, RG_IV, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_JV, RG_JV, 0); n++;
        p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_IV, RG_XV, 0); n++;
        p[n] = mk(OP_SHL, RG_T1, RG_T1, 0, 1); n++;
        p[n] = mk(OP_SUB, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_SHL, RG_T1, RG_JV, 0, 1); n++;
        p[n] = mk(OP_DIVR, RG_YV, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_CHKBIG, 0, RG_YV, 0, 0); n++;
        // squared height and z
        p[n] = mk(OP_SHL, RG_T0, RG_R1, 0, frac + 32); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_XV, RG_XV, 0); n++;
        p[n] = mk(OP_SUB, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_MUL, RG_T1, RG_YV, RG_YV, 0); n++;
        p[n] = mk(OP_SUB, RG_T0, RG_T0, RG_T1, 0); n++;
        p[n] = mk(OP_CHKNEG, 0, RG_T0, 0, 0); n++;
        p[n] = mk(OP_SQRT, RG_ZV, RG_T0, 0, 0); n++;
        // point = C1 + x*ex + y*ey + z*ez
        for (k = 0; k < 3; k++) begin
            p[n] = mk(OP_MUL, RG_T0, RG_XV, RG_EX + k, 0); n++;
            p[n] = mk(OP_MUL, RG_T1, RG_YV, RG_EY + k, 0); n++;
            p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
            p[n] = mk(OP_MUL, RG_T1, RG_ZV, RG_EZ + k, 0); n++;
            p[n] = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 0); n++;
            p[n] = mk(OP_SHRR, RG_T0, RG_T0, 0, 46); n++;
            p[n] = mk(OP_ADD, RG_T0, RG_C1 + k, RG_T0, 0); n++;
            p[n] = mk(OP_SAT, k, RG_T0, 0, 0); n++;
        end
        p[n] = mk(OP_END, 0, 0, 0, 0);
        return p[pc];
    endfunction

endpackage

// ----- rtl/tri_if.sv -----
// Channel interfaces of the trilateration core: sphere triples in, fixes out.
// Depends on nothing.
interface tri_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center1_x;
    logic signed [31:0] center1_y;
    logic signed [31:0] center1_z;
    logic [47:0]        radius1_sq;
    logic signed [31:0] center2_x;
    logic signed [31:0] center2_y;
    logic signed [31:0] center2_z;
    logic [47:0]        radius2_sq;
    logic signed [31:0] center3_x;
    logic signed [31:0] center3_y;
    logic signed [31:0] center3_z;
    logic [47:0]        radius3_sq;

    modport source (output valid, center1_x, center1_y, center1_z, radius1_sq,
                    center2_x, center2_y, center2_z, radius2_sq,
                    center3_x, center3_y, center3_z, radius3_sq, input ready);
    modport sink (input valid, center1_x, center1_y, center1_z, radius1_sq,
                  center2_x, center2_y, center2_z, radius2_sq,
                  center3_x, center3_y, center3_z, radius3_sq, output ready);
endinterface

interface tri_fix_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [1:0]         fix_status;

    modport source (output valid, point_x, point_y, point_z, fix_status, input ready);
    modport sink (input valid, point_x, point_y, point_z, fix_status, output ready);
endinterface

// ----- rtl/three_sphere_trilateration_core.sv -----
// Top level of the three-sphere trilateration core.
// Depends on tri_pkg, tri_if, tri_front, tri_queue and tri_back.
//
// Usage:
// - The item channel carries one sphere triple per beat: three centers in signed
//   Q(32-F).F and three squared radii in unsigned 48-bit fixed point, F = FRAC_BITS.
// - The fix channel returns one beat per triple, in order: the intersection point
//   (saturated to 32 bits) and a status of ok, no intersection or degenerate centers.
//   On either failure status the point is all zero.
// - The front end registers a triple and forms the center differences; a four-entry
//   queue lets it keep taking beats while the solver is busy.
// - The solver runs a microprogram over a 64-entry scratch register file, with a
//   multi-cycle multiplier, a bit-serial divider and a bit-serial square root. A full
//   fix spends most of its solver run in the eight divides and three roots;
//   degenerate or non-meeting triples exit early. Sustained rate is one fix per
//   solver run.
// - A finished fix sits in the output register; the solver starts the next triple as
//   soon as that register is free, so a stalled receiver only holds the solver at the
//   very end of a run and the queue keeps accepting until it fills.
// - Reset (asynchronous, active low) empties the queue and the output register and
//   returns the solver to idle. There is no clearing pass.
module three_sphere_trilateration_core
    import tri_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    tri_item_if.sink  item,
    tri_fix_if.source fix
);

    logic  q_push;
    item_t q_item;
    logic  q_full;
    logic  q_pop;
    item_t q_head;
    logic  q_valid;

    tri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_item)
    );

    tri_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_item),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .q_valid (q_valid)
    );

    tri_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_valid (q_valid),
        .pop     (q_pop),
        .fix     (fix)
    );

endmodule

// ----- rtl/tri_mul.sv -----
// Signed 64x64 multiplier built from one 32x32 product per cycle.
// Depends on tri_pkg.
module tri_mul
    import tri_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] prod
);

    logic         busy_reg;
    logic         done_reg;
    logic [1:0]   cnt_reg;
    logic [63:0]  am_reg;
    logic [63:0]  bm_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb
    begin
        ah = cnt_reg[1] ? am_reg[63:32] : am_reg[31:0];
        bh = cnt_reg[0] ? bm_reg[63:32] : bm_reg[31:0];
        pp = ah * bh;
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            am_reg  <= op_a[63] ? (~op_a + 64'd1) : op_a;
            bm_reg  <= op_b[63] ? (~op_b + 64'd1) : op_b;
            neg_reg <= op_a[63] ^ op_b[63];
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    assign done = done_reg;
    assign prod = neg_reg ? (~acc_reg + 128'd1) : acc_reg;

endmodule

// ----- rtl/tri_div.sv -----
// Rounding divider, 128-bit signed dividend by 64-bit unsigned divisor, one quotient bit a cycle.
// Depends on tri_pkg.
module tri_div
    import tri_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [63:0]  dv,
    output logic         done,
    output logic [127:0] quo
);

    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] n_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  dv_reg;
    logic         neg_reg;
    logic         zero_reg;
    logic [64:0]  rem_sh;
    logic         ge;
    logic [64:0]  rem_sub;
    logic [127:0] mag;

    assign mag     = num[127] ? (~num + 128'd1) : num;
    assign rem_sh  = {rem_reg, n_reg[127]};
    assign ge      = rem_sh >= {1'b0, dv_reg};
    assign rem_sub = rem_sh - {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 7'd127);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Quotient bits shift in at the bottom of the dividend register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= mag + {65'd0, dv[63:1]};
            rem_reg  <= 64'd0;
            dv_reg   <= dv;
            neg_reg  <= num[127];
            zero_reg <= (dv == 64'd0);
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[126:0], ge};
            rem_reg <= ge ? rem_sub[63:0] : rem_sh[63:0];
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? 128'd0 : (neg_reg ? (~n_reg + 128'd1) : n_reg);

endmodule

// ----- rtl/tri_sqrt.sv -----
// Floor integer square root of a 128-bit value, one root bit a cycle.
// Depends on tri_pkg.
module tri_sqrt
    import tri_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] val,
    output logic         done,
    output logic [63:0]  root
);

    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [127:0] v_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         ge;
    logic [67:0]  rem_sub;

    assign rem_sh  = {rem_reg, v_reg[127:126]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= val;
            rem_reg  <= 66'd0;
            root_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[125:0], 2'b00};
            rem_reg  <= ge ? rem_sub[65:0] : rem_sh[65:0];
            root_reg <= {root_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/tri_front.sv -----
// Front end: takes sphere-triple beats and forms the center differences for the queue.
// Depends on tri_pkg and tri_if.
module tri_front
    import tri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tri_item_if.sink    item,
    input  logic        q_full,
    output logic        push,
    output item_t       push_item
);

    logic  fv_reg;
    item_t fitem_reg;
    logic  accept;

    assign push       = fv_reg && !q_full;
    assign item.ready = !fv_reg || !q_full;
    assign accept     = item.valid && item.ready;
    assign push_item  = fitem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (accept)
            fv_reg <= 1'b1;
        else if (push)
            fv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fitem_reg.c1[0]  <= item.center1_x;
            fitem_reg.c1[1]  <= item.center1_y;
            fitem_reg.c1[2]  <= item.center1_z;
            fitem_reg.av[0]  <= 33'(item.center2_x) - 33'(item.center1_x);
            fitem_reg.av[1]  <= 33'(item.center2_y) - 33'(item.center1_y);
            fitem_reg.av[2]  <= 33'(item.center2_z) - 33'(item.center1_z);
            fitem_reg.bv[0]  <= 33'(item.center3_x) - 33'(item.center1_x);
            fitem_reg.bv[1]  <= 33'(item.center3_y) - 33'(item.center1_y);
            fitem_reg.bv[2]  <= 33'(item.center3_z) - 33'(item.center1_z);
            fitem_reg.rsq[0] <= item.radius1_sq;
            fitem_reg.rsq[1] <= item.radius2_sq;
            fitem_reg.rsq[2] <= item.radius3_sq;
        end
    end

endmodule

// ----- rtl/tri_queue.sv -----
// Small FIFO that decouples the front end from the solver sequencer.
// Depends on tri_pkg.
module tri_queue
    import tri_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  q_valid
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ----- rtl/tri_back.sv -----
// Back end: microprogrammed solver with a scratch register file and shared multi-cycle units.
// Depends on tri_pkg, tri_if, tri_mul, tri_div and tri_sqrt.
module tri_back
    import tri_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      head,
    input  logic       q_valid,
    output logic       pop,
    tri_fix_if.source  fix
);

    localparam int LIM_SH = 41 + FRAC_BITS / 2;
    localparam logic [127:0] LIM = 128'd1 << LIM_SH;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_WAIT, S_OUT} state_t;

    state_t           state_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [1:0]       status_reg;
    logic [2:0][31:0] pt_reg;
    logic             fvalid_reg;
    logic [2:0][31:0] fpt_reg;
    logic [1:0]       fst_reg;

    logic [127:0] mem [REG_DEPTH];
    logic [127:0] rd_a_reg;
    logic [127:0] rd_b_reg;

    instr_t       instr;
    logic [127:0] alu;
    logic [127:0] ld_val;
    logic [127:0] a_mag;
    logic         fail;
    logic [1:0]   fail_code;
    logic [31:0]  sat_val;
    logic         wr_en;
    logic [127:0] wr_data;
    logic         slot_free;

    logic         mul_start, div_start, sqrt_start;
    logic         mul_done, div_done, sqrt_done;
    logic [127:0] mul_prod, div_quo;
    logic [63:0]  sqrt_root;

    function automatic logic [127:0] shr_round(logic [127:0] v, logic [6:0] s);
        logic [127:0] mag;
        logic [127:0] half;
        logic [127:0] q;
        mag  = v[127] ? (~v + 128'd1) : v;
        half = (s == 7'd0) ? 128'd0 : (128'd1 << (s - 7'd1));
        q    = (mag + half) >> s;
        if (s == 7'd0)
            return v;
        return v[127] ? (~q + 128'd1) : q;
    endfunction

    assign instr     = tri_prog(pc_reg, FRAC_BITS);
    assign slot_free = !fvalid_reg || fix.ready;
    assign pop       = (state_reg == S_OUT) && slot_free;

    always_comb
    begin
        case (instr.sa)
            RADDR_W'(RG_C1):     ld_val = 128'($signed(head.c1[0]));
            RADDR_W'(RG_C1 + 1): ld_val = 128'($signed(head.c1[1]));
            RADDR_W'(RG_C1 + 2): ld_val = 128'($signed(head.c1[2]));
            RADDR_W'(RG_A):      ld_val = 128'($signed(head.av[0]));
            RADDR_W'(RG_A + 1):  ld_val = 128'($signed(head.av[1]));
            RADDR_W'(RG_A + 2):  ld_val = 128'($signed(head.av[2]));
            RADDR_W'(RG_B):      ld_val = 128'($signed(head.bv[0]));
            RADDR_W'(RG_B + 1):  ld_val = 128'($signed(head.bv[1]));
            RADDR_W'(RG_B + 2):  ld_val = 128'($signed(head.bv[2]));
            RADDR_W'(RG_R1):     ld_val = {80'd0, head.rsq[0]};
            RADDR_W'(RG_R2):     ld_val = {80'd0, head.rsq[1]};
            RADDR_W'(RG_R3):     ld_val = {80'd0, head.rsq[2]};
            default:             ld_val = 128'd0;
        endcase
    end

    always_comb
    begin
        a_mag = rd_a_reg[127] ? (~rd_a_reg + 128'd1) : rd_a_reg;
        case (instr.op)
            OP_LD:   alu = ld_val;
            OP_ADD:  alu = rd_a_reg + rd_b_reg;
            OP_SUB:  alu = rd_a_reg - rd_b_reg;
            OP_OR:   alu = rd_a_reg | rd_b_reg;
            OP_SHL:  alu = rd_a_reg << instr.amt;
            OP_SHRR: alu = shr_round(rd_a_reg, instr.amt);
            default: alu = 128'd0;
        endcase
        fail      = 1'b0;
        fail_code = ST_DEGEN;
        case (instr.op)
            OP_CHKZ:   fail = (rd_a_reg == 128'd0);
            OP_CHKLE:  fail = rd_a_reg[127] || (rd_a_reg == 128'd0);
            OP_CHKBIG:
            begin
                fail      = a_mag > LIM;
                fail_code = ST_NOMEET;
            end
            OP_CHKNEG:
            begin
                fail      = rd_a_reg[127];
                fail_code = ST_NOMEET;
            end
            default:   fail = 1'b0;
        endcase
        if ($signed(rd_a_reg) > $signed(128'sh7FFF_FFFF))
            sat_val = 32'h7FFF_FFFF;
        else if ($signed(rd_a_reg) < -$signed(128'sh8000_0000))
            sat_val = 32'h8000_0000;
        else
            sat_val = rd_a_reg[31:0];
    end

    always_comb
    begin
        mul_start  = (state_reg == S_EXEC) && (instr.op == OP_MUL);
        div_start  = (state_reg == S_EXEC) && (instr.op == OP_DIVR);
        sqrt_start = (state_reg == S_EXEC) && (instr.op == OP_SQRT);
        wr_en      = 1'b0;
        wr_data    = alu;
        if (state_reg == S_EXEC)
        begin
            case (instr.op) inside
                OP_LD, OP_ADD, OP_SUB, OP_OR, OP_SHL, OP_SHRR: wr_en = 1'b1;
                default:                                       wr_en = 1'b0;
            endcase
        end
        else if (state_reg == S_WAIT)
        begin
            wr_en = mul_done || div_done || sqrt_done;
            if (mul_done)
                wr_data = mul_prod;
            else if (div_done)
                wr_data = div_quo;
            else
                wr_data = {64'd0, sqrt_root};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[instr.sa];
        rd_b_reg <= mem[instr.sb];
        if (wr_en)
            mem[instr.dst] <= wr_data;
    end

    tri_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (rd_a_reg[63:0]),
        .op_b  (rd_b_reg[63:0]),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd_a_reg),
        .dv    (rd_b_reg[63:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    tri_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   (rd_a_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            status_reg <= ST_OK;
            pt_reg     <= '0;
            fvalid_reg <= 1'b0;
            fpt_reg    <= '0;
            fst_reg    <= ST_OK;
        end
        else
        begin
            if (pop)
            begin
                fvalid_reg <= 1'b1;
                fpt_reg    <= pt_reg;
                fst_reg    <= status_reg;
            end
            else if (fix.ready)
                fvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        pc_reg     <= '0;
                        status_reg <= ST_OK;
                        pt_reg     <= '0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    case (instr.op) inside
                        OP_MUL, OP_DIVR, OP_SQRT:
                            state_reg <= S_WAIT;
                        OP_END:
                            state_reg <= S_OUT;
                        OP_CHKZ, OP_CHKLE, OP_CHKBIG, OP_CHKNEG:
                        begin
                            if (fail)
                            begin
                                status_reg <= fail_code;
                                pt_reg     <= '0;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                pc_reg    <= pc_reg + PC_W'(1);
                                state_reg <= S_READ;
                            end
                        end
                        OP_SAT:
                        begin
                            pt_reg[instr.dst[1:0]] <= sat_val;
                            pc_reg                 <= pc_reg + PC_W'(1);
                            state_reg              <= S_READ;
                        end
                        default:
                        begin
                            pc_reg    <= pc_reg + PC_W'(1);
                            state_reg <= S_READ;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    if (mul_done || div_done || sqrt_done)
                    begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign fix.valid      = fvalid_reg;
    assign fix.point_x    = fpt_reg[0];
    assign fix.point_y    = fpt_reg[1];
    assign fix.point_z    = fpt_reg[2];
    assign fix.fix_status = fst_reg;

endmodule

// ----- rtl/tri_checker.sv -----
// Port-level checks of the trilateration core, attached by a bind statement.
// Depends on tri_pkg and three_sphere_trilateration_core.
module tri_checker
    import tri_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        fix_valid,
    input logic        fix_ready,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic [31:0] point_z,
    input logic [1:0]  fix_status
);

    a_fix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && !fix_ready |=> fix_valid && $stable(point_x) && $stable(point_y)
            && $stable(point_z) && $stable(fix_status))
        else $error("fix beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> (fix_status == ST_OK) || (fix_status == ST_NOMEET)
            || (fix_status == ST_DEGEN))
        else $error("fix status carries an unused code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && (fix_status != ST_OK)
            |-> (point_x == 32'd0) && (point_y == 32'd0) && (point_z == 32'd0))
        else $error("failed fix carries a nonzero point");

endmodule

bind three_sphere_trilateration_core tri_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .fix_valid  (fix.valid),
    .fix_ready  (fix.ready),
    .point_x    (fix.point_x),
    .point_y    (fix.point_y),
    .point_z    (fix.point_z),
    .fix_status (fix.fix_status)
);

// ----- tb/tb.sv -----
// Self-checking testbench for three_sphere_trilateration_core: sphere triples in, fixes out.
// Depends on tri_pkg, tri_if and the core; a built-in fixed-point solver predicts every fix.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;
    typedef logic [127:0]        uwide_t;

    typedef struct {
        logic signed [31:0] c [3][3];   // [sphere][axis]
        logic [47:0]        r [3];
    } triple_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [1:0]         status;
    } fix_t;

    localparam int FRAC   = 16;
    localparam int NRAND  = 1425;
    localparam int WD_MAX = 40000;

    logic clk;
    logic rst_n;
    bit   failed;

    tri_item_if item_ch();
    tri_fix_if  fix_ch();

    three_sphere_trilateration_core #(.FRAC_BITS(FRAC)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .fix   (fix_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Wide fixed-point helpers. Divisions and right shifts round half away from zero,
    // square roots are floored.
    function automatic wide_t smul(longint p, longint q);
        return wide_t'(p) * wide_t'(q);
    endfunction

    function automatic longint low64(wide_t v);
        return longint'(v[63:0]);
    endfunction

    function automatic wide_t div_near(wide_t n, logic [63:0] dv);
        uwide_t m;
        if (dv == 0)
        begin
            return '0;
        end
        m = n[127] ? uwide_t'(-n) : uwide_t'(n);
        m = (m + uwide_t'(dv >> 1)) / uwide_t'(dv);
        return n[127] ? -wide_t'(m) : wide_t'(m);
    endfunction

    function automatic wide_t shr_near(wide_t v, int s);
        uwide_t m;
        m = v[127] ? uwide_t'(-v) : uwide_t'(v);
        m = (m + (uwide_t'(1) << (s - 1))) >> s;
        return v[127] ? -wide_t'(m) : wide_t'(m);
    endfunction

    function automatic logic [63:0] root_floor(wide_t v);
        logic [63:0] res;
        logic [63:0] c;
        res = '0;
        if (v[127])
        begin
            return '0;
        end
        for (int k = 63; k >= 0; k--)
        begin
            c = res | (64'd1 << k);
            if (uwide_t'(c) * uwide_t'(c) <= uwide_t'(v))
            begin
                res = c;
            end
        end
        return res;
    endfunction

    function automatic bit beyond(wide_t v, wide_t lim);
        uwide_t m;
        m = v[127] ? uwide_t'(-v) : uwide_t'(v);
        return m > uwide_t'(lim);
    endfunction

    // Predicts the fix of one triple. Lengths carry 32 fraction bits, unit vectors 30.
    function automatic fix_t solve_fix(triple_t s);
        fix_t   f;
        longint c1 [3];
        longint av [3];
        longint bv [3];
        longint ex [3];
        longint ey [3];
        longint ez [3];
        longint tv [3];
        longint pt [3];
        longint r1, r2, r3, iv, jv, xv, yv, zv, v;
        logic [63:0] dl, nl;
        wide_t cr [3];
        wide_t d2, acc, num, xw, yw, h, lim;
        int p, q;
        f.status = tri_pkg::ST_OK;
        for (int k = 0; k < 3; k++)
        begin
            c1[k] = s.c[0][k];
            av[k] = longint'(s.c[1][k]) - c1[k];
            bv[k] = longint'(s.c[2][k]) - c1[k];
            pt[k] = 0;
        end
        r1 = s.r[0];
        r2 = s.r[1];
        r3 = s.r[2];
        lim = wide_t'(1) << (25 + FRAC / 2 + 16);
        for (int k = 0; k < 3; k++)
        begin
            p = (k + 1) % 3;
            q = (k + 2) % 3;
            cr[k] = smul(av[p], bv[q]) - smul(av[q], bv[p]);
        end
        if ((cr[0] | cr[1] | cr[2]) == 0)
        begin
            f.status = tri_pkg::ST_DEGEN;
        end
        if (f.status == tri_pkg::ST_OK)
        begin
            d2 = smul(av[0], av[0]) + smul(av[1], av[1]) + smul(av[2], av[2]);
            dl = root_floor(d2 << 32);
            for (int k = 0; k < 3; k++)
            begin
                ex[k] = low64(div_near(wide_t'(av[k]) << 46, dl));
            end
            acc = smul(ex[0], bv[0]) + smul(ex[1], bv[1]) + smul(ex[2], bv[2]);
            iv = low64(shr_near(acc, 14));
            for (int k = 0; k < 3; k++)
            begin
                tv[k] = bv[k] * 65536 - low64(shr_near(smul(iv, ex[k]), 30));
            end
            nl = root_floor(smul(tv[0], tv[0]) + smul(tv[1], tv[1]) + smul(tv[2], tv[2]));
            if (nl == 0)
            begin
                f.status = tri_pkg::ST_DEGEN;
            end
            if (f.status == tri_pkg::ST_OK)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ey[k] = low64(div_near(wide_t'(tv[k]) << 30, nl));
                end
                for (int k = 0; k < 3; k++)
                begin
                    p = (k + 1) % 3;
                    q = (k + 2) % 3;
                    ez[k] = low64(shr_near(smul(ex[p], ey[q]) - smul(ex[q], ey[p]), 30));
                end
                acc = smul(ey[0], bv[0]) + smul(ey[1], bv[1]) + smul(ey[2], bv[2]);
                jv = low64(shr_near(acc, 14));
                if (jv <= 0)
                begin
                    f.status = tri_pkg::ST_DEGEN;
                end
            end
            if (f.status == tri_pkg::ST_OK)
            begin
                num = (wide_t'(r1 - r2) << FRAC) + d2;
                xw = div_near(num << 31, dl);
                if (beyond(xw, lim))
                begin
                    f.status = tri_pkg::ST_NOMEET;
                end
            end
            if (f.status == tri_pkg::ST_OK)
            begin
                xv = low64(xw);
                num = (wide_t'(r1 - r3) << (FRAC + 32)) + smul(iv, iv) + smul(jv, jv)
                    - (smul(iv, xv) << 1);
                yw = div_near(num, 64'(jv) * 2);
                if (beyond(yw, lim))
                begin
                    f.status = tri_pkg::ST_NOMEET;
                end
            end
            if (f.status == tri_pkg::ST_OK)
            begin
                yv = low64(yw);
                h = (wide_t'(r1) << (FRAC + 32)) - smul(xv, xv) - smul(yv, yv);
                if (h[127])
                begin
                    f.status = tri_pkg::ST_NOMEET;
                end
            end
            if (f.status == tri_pkg::ST_OK)
            begin
                zv = longint'(root_floor(h));
                for (int k = 0; k < 3; k++)
                begin
                    acc = smul(xv, ex[k]) + smul(yv, ey[k]) + smul(zv, ez[k]);
                    v = c1[k] + low64(shr_near(acc, 46));
                    if (v > 64'sd2147483647)
                    begin
                        v = 64'sd2147483647;
                    end
                    if (v < -64'sd2147483648)
                    begin
                        v = -64'sd2147483648;
                    end
                    pt[k] = v;
                end
            end
        end
        f.px = pt[0][31:0];
        f.py = pt[1][31:0];
        f.pz = pt[2][31:0];
        return f;
    endfunction

    // Triples waiting to be sent, each with a flag that makes the sender drain the
    // core before that triple goes out; fixes still owed by the core.
    triple_t pending_q [$];
    bit      drain_q   [$];
    fix_t    owed_q    [$];

    function automatic logic [47:0] dist_sq(triple_t s, int n, longint px, longint py,
                                            longint pz);
        longint dx, dy, dz;
        dx = longint'(s.c[n][0]) - px;
        dy = longint'(s.c[n][1]) - py;
        dz = longint'(s.c[n][2]) - pz;
        return 48'((dx * dx + dy * dy + dz * dz) >>> 16);
    endfunction

    // A triple whose spheres meet at a chosen point, centers within +-span.
    function automatic triple_t meeting_triple(int span);
        triple_t s;
        longint  px, py, pz;
        px = longint'($signed($urandom_range(2 * span, 0))) - span;
        py = longint'($signed($urandom_range(2 * span, 0))) - span;
        pz = longint'($signed($urandom_range(2 * span, 0))) - span;
        for (int n = 0; n < 3; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s.c[n][k] = 32'($urandom_range(2 * span, 0)) - 32'(span);
            end
        end
        for (int n = 0; n < 3; n++)
        begin
            s.r[n] = dist_sq(s, n, px, py, pz);
        end
        return s;
    endfunction

    function automatic triple_t wild_triple();
        triple_t s;
        for (int n = 0; n < 3; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s.c[n][k] = $urandom;
            end
            s.r[n] = {16'($urandom), 32'($urandom)};
        end
        return s;
    endfunction

    function automatic triple_t flat_triple(logic signed [31:0] cv, logic [47:0] rv);
        triple_t s;
        for (int n = 0; n < 3; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s.c[n][k] = cv;
            end
            s.r[n] = rv;
        end
        return s;
    endfunction

    task automatic queue_triple(triple_t s, bit drain);
        pending_q.push_back(s);
        drain_q.push_back(drain);
    endtask

    // Sender. Each beat is preceded by a random gap; every fourth hundred beats
    // goes out with no gaps at all.
    int sent;
    int gap;
    bit item_fire;
    bit fix_fire;

    always @(posedge clk or negedge rst_n)
    begin
        triple_t s;
        if (!rst_n)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.center1_x  <= '0;
            item_ch.center1_y  <= '0;
            item_ch.center1_z  <= '0;
            item_ch.radius1_sq <= '0;
            item_ch.center2_x  <= '0;
            item_ch.center2_y  <= '0;
            item_ch.center2_z  <= '0;
            item_ch.radius2_sq <= '0;
            item_ch.center3_x  <= '0;
            item_ch.center3_y  <= '0;
            item_ch.center3_z  <= '0;
            item_ch.radius3_sq <= '0;
            gap = 0;
            sent = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                s.c[0][0] = item_ch.center1_x;
                s.c[0][1] = item_ch.center1_y;
                s.c[0][2] = item_ch.center1_z;
                s.c[1][0] = item_ch.center2_x;
                s.c[1][1] = item_ch.center2_y;
                s.c[1][2] = item_ch.center2_z;
                s.c[2][0] = item_ch.center3_x;
                s.c[2][1] = item_ch.center3_y;
                s.c[2][2] = item_ch.center3_z;
                s.r[0]    = item_ch.radius1_sq;
                s.r[1]    = item_ch.radius2_sq;
                s.r[2]    = item_ch.radius3_sq;
                owed_q.push_back(solve_fix(s));
                sent++;
                gap = ((sent / 100) % 4 == 3) ? 0 : $urandom_range(9, 0);
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap > 0)
                begin
                    gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0 && !(drain_q[0] && owed_q.size() > 0))
                begin
                    s = pending_q.pop_front();
                    void'(drain_q.pop_front());
                    item_ch.center1_x  <= s.c[0][0];
                    item_ch.center1_y  <= s.c[0][1];
                    item_ch.center1_z  <= s.c[0][2];
                    item_ch.radius1_sq <= s.r[0];
                    item_ch.center2_x  <= s.c[1][0];
                    item_ch.center2_y  <= s.c[1][1];
                    item_ch.center2_z  <= s.c[1][2];
                    item_ch.radius2_sq <= s.r[1];
                    item_ch.center3_x  <= s.c[2][0];
                    item_ch.center3_y  <= s.c[2][1];
                    item_ch.center3_z  <= s.c[2][2];
                    item_ch.radius3_sq <= s.r[2];
                    item_ch.valid      <= 1'b1;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Compares every fix beat with the oldest prediction, then stalls
    // for a random count of cycles, with stall-free stretches in between.
    int stall;
    int got;

    always @(posedge clk or negedge rst_n)
    begin
        fix_t f;
        if (!rst_n)
        begin
            fix_ch.ready <= 1'b0;
            stall = 0;
            got = 0;
        end
        else
        begin
            if (fix_ch.valid && fix_ch.ready)
            begin
                got++;
                if (owed_q.size() == 0)
                begin
                    $error("fix beat with no prediction waiting");
                    failed = 1'b1;
                end
                else
                begin
                    f = owed_q.pop_front();
                    if (fix_ch.point_x !== f.px)
                    begin
                        $error("point_x expected %0d got %0d", f.px, fix_ch.point_x);
                        failed = 1'b1;
                    end
                    if (fix_ch.point_y !== f.py)
                    begin
                        $error("point_y expected %0d got %0d", f.py, fix_ch.point_y);
                        failed = 1'b1;
                    end
                    if (fix_ch.point_z !== f.pz)
                    begin
                        $error("point_z expected %0d got %0d", f.pz, fix_ch.point_z);
                        failed = 1'b1;
                    end
                    if (fix_ch.fix_status !== f.status)
                    begin
                        $error("fix_status expected %0d got %0d", f.status,
                               fix_ch.fix_status);
                        failed = 1'b1;
                    end
                end
                stall = ((got / 50) % 4 == 1) ? 0 : $urandom_range(9, 0);
            end
            if (stall > 0)
            begin
                stall--;
                fix_ch.ready <= 1'b0;
            end
            else
            begin
                fix_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long stretch with no beat on either side means the core has hung.
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (fix_ch.valid && fix_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WD_MAX)
        begin
            $display("three_sphere_trilateration_core test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        triple_t s;
        int      pick;
        int      mult;
        rst_n = 1'b0;

        // Directed triples: field extremes, coincident and collinear centers,
        // touching and missing spheres, runaway x and y, saturation.
        queue_triple(flat_triple(32'sd0, 48'd0), 1'b0);
        queue_triple(flat_triple(32'sh7fffffff, 48'hffffffffffff), 1'b0);
        queue_triple(flat_triple(-32'sh80000000, 48'd0), 1'b0);
        s = flat_triple(32'sd0, 48'd65536);
        s.c[1][0] = 32'sh00010000;
        s.c[2][1] = 32'sh00010000;
        queue_triple(s, 1'b0);                        // unit spheres, exact fix
        s.r[0] = 48'd0;
        queue_triple(s, 1'b0);                        // first sphere shrunk to a point
        s = flat_triple(32'sd0, 48'd65536);
        s.c[1][0] = 32'sh00020000;
        s.c[2][1] = 32'sh00020000;
        s.r[2] = 48'd65536 * 5;
        queue_triple(s, 1'b0);                        // spheres just touching
        s.r[0] = 48'd1;
        s.r[1] = 48'd1;
        queue_triple(s, 1'b1);                        // spheres apart, after a drain
        s = flat_triple(32'sd0, 48'd65536);
        s.c[1][0] = 32'sh00010000;
        queue_triple(s, 1'b0);                        // first two centers differ only
        s.c[2][0] = 32'sh00020000;
        queue_triple(s, 1'b0);                        // collinear
        s.c[2][0] = 32'sh00050000;
        s.c[2][2] = -32'sh0000_0001;
        queue_triple(s, 1'b0);                        // nearly collinear
        s = flat_triple(32'sd0, 48'd0);
        s.c[1][2] = 32'sd1;
        s.c[2][1] = 32'sd1;
        s.r[0] = 48'hffffffffffff;
        queue_triple(s, 1'b0);                        // x runs far out
        s.r[1] = 48'hffffffffffff;
        queue_triple(s, 1'b0);                        // y runs far out
        s = flat_triple(32'sh7fff0000, 48'd0);
        s.c[1][0] = 32'sh7ffe0000;
        s.c[2][1] = 32'sh7ffe0000;
        s.r[0] = 48'h0100_0000_0000;
        s.r[1] = 48'h0100_0000_0000;
        s.r[2] = 48'h0100_0000_0000;
        queue_triple(s, 1'b0);                        // point beyond the top of range
        s = flat_triple(-32'sh80000000, 48'h0100_0000_0000);
        s.c[1][0] = -32'sh7fff0000;
        s.c[2][2] = -32'sh7fff0000;
        queue_triple(s, 1'b0);                        // point beyond the bottom of range
        s = flat_triple(32'sh7fffffff, 48'hffffffffffff);
        s.c[1][0] = -32'sh80000000;
        s.c[2][1] = -32'sh80000000;
        queue_triple(s, 1'b0);                        // widest center spread
        for (int n = 0; n < 4; n++)
        begin
            queue_triple(meeting_triple(1 << 22), 1'b0);
        end

        // Random part: mostly triples that meet, some with jittered radii,
        // plus degenerate and unconstrained ones.
        for (int n = 0; n < NRAND; n++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
            begin
                s = meeting_triple((pick < 20) ? (1 << 12) : (1 << 24));
            end
            else if (pick < 75)
            begin
                s = meeting_triple(1 << 20);
                for (int k = 0; k < 3; k++)
                begin
                    s.r[k] = s.r[k] + 48'($urandom_range(2000, 0)) - 48'd1000;
                end
            end
            else if (pick < 85)
            begin
                s = meeting_triple(1 << 20);
                mult = $urandom_range(3, 0);
                for (int k = 0; k < 3; k++)
                begin
                    s.c[2][k] = s.c[0][k] + 32'(mult) * (s.c[1][k] - s.c[0][k]);
                end
                if (pick == 84)
                begin
                    s.c[1] = s.c[0];
                end
            end
            else
            begin
                s = wild_triple();
            end
            queue_triple(s, ($urandom_range(299, 0) == 0));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_q.size() != 0 || owed_q.size() != 0 || item_ch.valid)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (!failed)
        begin
            $display("three_sphere_trilateration_core test passed");
        end
        else
        begin
            $display("three_sphere_trilateration_core test failed");
        end
        $finish;
    end

endmodule

// ----- three_sphere_trilateration_core.f -----
rtl/tri_pkg.sv
rtl/tri_if.sv
rtl/tri_mul.sv
rtl/tri_div.sv
rtl/tri_sqrt.sv
rtl/tri_front.sv
rtl/tri_queue.sv
rtl/tri_back.sv
rtl/three_sphere_trilateration_core.sv
rtl/tri_checker.sv
tb/tb.sv
